/* hdl/ecct_pkg.sv */
// ----------------------------------------------------------------------------
// ecct_pkg
// Shared types and codes of the edge coverage counter table.
// ----------------------------------------------------------------------------
package ecct_pkg;

    // Table size is a power of two, so the home slot is the low key bits.
    localparam int TABLE_SLOTS  = 1024;
    localparam int THREAD_SLOTS = 16;

    localparam logic [1:0] REQ_EVENT = 2'd0;
    localparam logic [1:0] REQ_CLEAR = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    localparam logic [2:0] ADDR_TRACE_ENABLE = 3'd0;

    // Entry word: valid mark, count, key.
    localparam int ENTRY_W = 65;

    typedef struct packed {
        logic        vld;
        logic [31:0] count;
        logic [31:0] key;
    } entry_t;

endpackage

/* hdl/ecct_ram.sv */
// ----------------------------------------------------------------------------
// ecct_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module ecct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hdl/edge_coverage_counter_table.sv */
// ----------------------------------------------------------------------------
// edge_coverage_counter_table
// Block and edge hit counters in two linear-probing tables held in RAM.
// ----------------------------------------------------------------------------
// Usage: requests enter on the s_ stream (kind and table select in s_tuser),
// one result item leaves on the m_ stream per request. trace_enable is set
// through the APB port at byte address 0.
// A block event computes its ids, then probes the block table and the edge
// table in turn. The home slot is the low key bits, set in ST_MOD. Each
// probe is a RAM read (ST_RD) and a check (ST_CHK); a probe that meets
// another key moves on to the next slot, so crowded tables take longer.
// A slot read is a single probe; an ignored event or an unknown kind goes
// straight to the result. A clear request sweeps both RAMs. After reset
// the same sweep runs before the first item is accepted; configuration
// writes are taken throughout.
// One item is worked on at a time. The finished result sits in an output
// register, so a stalled receiver holds at most one result while the next
// item is already accepted and worked on.
// ----------------------------------------------------------------------------
module edge_coverage_counter_table
    import ecct_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    // APB configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // thread_slot[3:0], location[35:4], slot_index[45:36]
    input  logic [2:0]   s_tuser,   // req_type[1:0], table_select[2]
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [199:0] m_tdata    // counted[0], blk_hash[32:1], edge_id[64:33],
                                    // block_count[96:65], edge_count[128:97],
                                    // table_full[129], read_valid[130],
                                    // read_key[162:131], read_count[194:163]
);

    localparam int AW = $clog2(TABLE_SLOTS);
    localparam int TW = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
    localparam logic [AW-1:0] LAST_SLOT = AW'(TABLE_SLOTS - 1);

    localparam logic [2:0] ST_SWEEP = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MOD   = 3'd2;
    localparam logic [2:0] ST_RD    = 3'd3;
    localparam logic [2:0] ST_CHK   = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg, state_next;
    logic        enable_reg;
    logic [30:0] prev_reg [THREAD_SLOTS];

    logic [AW-1:0] pos_reg, pos_next;
    logic [AW-1:0] n_reg, n_next;
    logic [31:0]   key_reg, key_next;
    logic          tsel_reg, tsel_next;
    logic          rdmode_reg, rdmode_next;
    logic          clrpend_reg, clrpend_next;
    logic [TW-1:0] thr_reg, thr_next;

    logic        r_counted_reg, r_counted_next;
    logic [31:0] r_bid_reg, r_bid_next;
    logic [31:0] r_eid_reg, r_eid_next;
    logic [31:0] r_bc_reg, r_bc_next;
    logic [31:0] r_ec_reg, r_ec_next;
    logic        r_full_reg, r_full_next;
    logic        r_rv_reg, r_rv_next;
    logic [31:0] r_rk_reg, r_rk_next;
    logic [31:0] r_rc_reg, r_rc_next;

    logic         out_valid_reg;
    logic [199:0] out_data_reg;

    // RAM ports
    logic          we_blk, we_edg;
    logic [AW-1:0] waddr, raddr;
    entry_t        wentry, blk_q, edg_q, cur_q;

    ecct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_blk_ram (
        .clk   (clk),
        .we    (we_blk),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (blk_q)
    );

    ecct_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_edg_ram (
        .clk   (clk),
        .we    (we_edg),
        .waddr (waddr),
        .wdata (wentry),
        .raddr (raddr),
        .rdata (edg_q)
    );

    assign cur_q = tsel_reg ? edg_q : blk_q;

    // Request fields
    logic [1:0]  in_req;
    logic [3:0]  in_thr;
    logic [31:0] in_loc;
    logic        in_sel;
    logic [9:0]  in_idx;
    logic [31:0] in_bid;
    logic [31:0] in_idx_ext;
    logic        in_accept;
    logic [31:0] inc_count;

    assign in_req     = s_tuser[1:0];
    assign in_sel     = s_tuser[2];
    assign in_thr     = s_tdata[3:0];
    assign in_loc     = s_tdata[35:4];
    assign in_idx     = s_tdata[45:36];
    assign in_bid     = (in_loc >> 4) ^ (in_loc << 8);
    assign in_idx_ext = {22'd0, in_idx};
    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign inc_count  = (cur_q.count == 32'hFFFF_FFFF) ? cur_q.count : cur_q.count + 32'd1;

    // APB
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TRACE_ENABLE) ? {31'd0, enable_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && paddr == ADDR_TRACE_ENABLE)
        begin
            enable_reg <= pwdata[0];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        pos_next       = pos_reg;
        n_next         = n_reg;
        key_next       = key_reg;
        tsel_next      = tsel_reg;
        rdmode_next    = rdmode_reg;
        clrpend_next   = clrpend_reg;
        thr_next       = thr_reg;
        r_counted_next = r_counted_reg;
        r_bid_next     = r_bid_reg;
        r_eid_next     = r_eid_reg;
        r_bc_next      = r_bc_reg;
        r_ec_next      = r_ec_reg;
        r_full_next    = r_full_reg;
        r_rv_next      = r_rv_reg;
        r_rk_next      = r_rk_reg;
        r_rc_next      = r_rc_reg;
        we_blk         = 1'b0;
        we_edg         = 1'b0;
        waddr          = pos_reg;
        raddr          = pos_reg;
        wentry         = '0;

        case (state_reg)
            ST_SWEEP:
            begin
                we_blk = 1'b1;
                we_edg = 1'b1;
                pos_next = pos_reg + AW'(1);
                if (pos_reg == LAST_SLOT)
                begin
                    pos_next     = '0;
                    clrpend_next = 1'b0;
                    state_next   = clrpend_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    r_counted_next = 1'b0;
                    r_bid_next     = '0;
                    r_eid_next     = '0;
                    r_bc_next      = '0;
                    r_ec_next      = '0;
                    r_full_next    = 1'b0;
                    r_rv_next      = 1'b0;
                    r_rk_next      = '0;
                    r_rc_next      = '0;
                    state_next     = ST_OUT;
                    case (in_req)
                        REQ_EVENT:
                        begin
                            if (enable_reg && {28'd0, in_thr} < 32'(THREAD_SLOTS))
                            begin
                                r_counted_next = 1'b1;
                                r_bid_next     = in_bid;
                                r_eid_next     = {1'b0, prev_reg[TW'(in_thr)]} ^ in_bid;
                                thr_next       = TW'(in_thr);
                                key_next       = in_bid;
                                tsel_next      = 1'b0;
                                rdmode_next    = 1'b0;
                                state_next     = ST_MOD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            clrpend_next = 1'b1;
                            pos_next     = '0;
                            state_next   = ST_SWEEP;
                        end
                        REQ_READ:
                        begin
                            if (in_idx_ext < 32'(TABLE_SLOTS))
                            begin
                                pos_next    = in_idx_ext[AW-1:0];
                                tsel_next   = in_sel;
                                rdmode_next = 1'b1;
                                state_next  = ST_RD;
                            end
                        end
                        default:
                        begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_MOD:
            begin
                n_next     = '0;
                pos_next   = key_reg[AW-1:0];
                state_next = ST_RD;
            end
            ST_RD:
            begin
                raddr      = pos_reg;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                if (rdmode_reg)
                begin
                    if (cur_q.vld)
                    begin
                        r_rv_next = 1'b1;
                        r_rk_next = cur_q.key;
                        r_rc_next = cur_q.count;
                    end
                    state_next = ST_OUT;
                end
                else
                begin
                    logic        done;
                    logic [31:0] cnt;
                    done = 1'b1;
                    cnt  = '0;
                    if (!cur_q.vld)
                    begin
                        cnt    = 32'd1;
                        wentry = '{vld: 1'b1, count: 32'd1, key: key_reg};
                        we_blk = !tsel_reg;
                        we_edg = tsel_reg;
                    end
                    else if (cur_q.key == key_reg)
                    begin
                        cnt    = inc_count;
                        wentry = '{vld: 1'b1, count: inc_count, key: key_reg};
                        we_blk = !tsel_reg;
                        we_edg = tsel_reg;
                    end
                    else if (n_reg == LAST_SLOT)
                    begin
                        r_full_next = 1'b1;
                    end
                    else
                    begin
                        done       = 1'b0;
                        n_next     = n_reg + AW'(1);
                        pos_next   = (pos_reg == LAST_SLOT) ? '0 : pos_reg + AW'(1);
                        state_next = ST_RD;
                    end
                    if (done)
                    begin
                        if (!tsel_reg)
                        begin
                            r_bc_next  = cnt;
                            key_next   = r_eid_reg;
                            tsel_next  = 1'b1;
                            state_next = ST_MOD;
                        end
                        else
                        begin
                            r_ec_next  = cnt;
                            state_next = ST_OUT;
                        end
                    end
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            pos_reg       <= '0;
            clrpend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                prev_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            clrpend_reg <= clrpend_next;
            if (in_accept && in_req == REQ_CLEAR)
            begin
                for (int i = 0; i < THREAD_SLOTS; i++)
                begin
                    prev_reg[i] <= '0;
                end
            end
            else if (state_reg == ST_CHK && state_next == ST_OUT && !rdmode_reg)
            begin
                prev_reg[thr_reg] <= r_bid_reg[31:1];
            end
            if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        key_reg       <= key_next;
        tsel_reg      <= tsel_next;
        rdmode_reg    <= rdmode_next;
        thr_reg       <= thr_next;
        r_counted_reg <= r_counted_next;
        r_bid_reg     <= r_bid_next;
        r_eid_reg     <= r_eid_next;
        r_bc_reg      <= r_bc_next;
        r_ec_reg      <= r_ec_next;
        r_full_reg    <= r_full_next;
        r_rv_reg      <= r_rv_next;
        r_rk_reg      <= r_rk_next;
        r_rc_reg      <= r_rc_next;
        if (state_reg == ST_OUT && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {5'd0, r_rc_reg, r_rk_reg, r_rv_reg, r_full_reg,
                             r_ec_reg, r_bc_reg, r_eid_reg, r_bid_reg, r_counted_reg};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    // Only event probes and the sweep write the tables.
    assert property (@(posedge clk) disable iff (!rst_n)
        (we_blk || we_edg) |-> (state_reg == ST_SWEEP || state_reg == ST_CHK))
        else $error("table written outside sweep or probe");

    // An event result never carries read data.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> !m_tdata[130])
        else $error("event result with read data");

    // A result is loaded only when the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped");

    // A probe check always follows its read cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHK) |-> ($past(state_reg) == ST_RD))
        else $error("probe check without read");
`endif

endmodule
